// ===== rtl/core/gcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Great-circle distance package
// Shared constants, CORDIC angle table and small arithmetic helpers.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int NSTEPS = 30;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [33:0] Q30_ONE = 34'sd1073741824;
  localparam logic [26:0] FOUR_PI_R_M = 27'd80060347;
  localparam logic [24:0] HALF_CIRC_M = 25'd20015087;

  // Reciprocals of 45. They give exact floor quotients for dividends below
  // 2^26 (shift by 32) and below 2^19 (shift by 25).
  localparam logic [26:0] RECIP_45 = 27'd95443718;
  localparam logic [19:0] RECIP_45_FRAC = 20'd745655;

  function automatic logic signed [33:0] atan_phase(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0: r = 34'sd536870912;
      5'd1: r = 34'sd316933406;
      5'd2: r = 34'sd167458907;
      5'd3: r = 34'sd85004756;
      5'd4: r = 34'sd42667331;
      5'd5: r = 34'sd21354465;
      5'd6: r = 34'sd10679838;
      5'd7: r = 34'sd5340245;
      5'd8: r = 34'sd2670163;
      5'd9: r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      5'd24: r = 34'sd41;
      5'd25: r = 34'sd20;
      5'd26: r = 34'sd10;
      5'd27: r = 34'sd5;
      5'd28: r = 34'sd3;
      5'd29: r = 34'sd1;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } rot_t;

endpackage

// ===== rtl/core/great_circle_distance.sv =====
// ----------------------------------------------------------------------------
// Great-circle distance
// Haversine distance in meters between two points given in Q16 degrees.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while no valid output is stalled;
// the pipeline length is set by the five degree-to-phase stages, the
// 30-step rotating and vectoring CORDIC chains and the parallel 31-step
// square-root chains.
// Reset clears every stage valid bit; payload registers are not reset.
// A stall freezes the whole pipeline, so nothing is lost or repeated.
module great_circle_distance
  import gcd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] lat_a,
  input  logic signed [24:0] lon_a,
  input  logic signed [23:0] lat_b,
  input  logic signed [24:0] lon_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [24:0] distance_m
);

  localparam int NV = 110;

  logic [NV-1:0] vld;
  logic adv;

  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld[NV-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NV-2:0], in_valid};
    end
  end

  // Stage 0: differences.
  logic signed [25:0] s0_dlat, s0_dlon, s0_la, s0_lb;
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_dlat <= 26'(lat_b) - 26'(lat_a);
      s0_dlon <= 26'(lon_b) - 26'(lon_a);
      s0_la <= 26'(lat_a);
      s0_lb <= 26'(lat_b);
    end
  end

  // Stages 1-5: phases. With |d| = 45*a + b, round(|d|*2^k/45) is a*2^k
  // plus the quotient of b*2^k + 22 by 45, so both reciprocal multiplies
  // stay narrow.
  logic signed [25:0] s0_d [4];
  logic [31:0] s5_p [4];
  assign s0_d[0] = s0_dlat;
  assign s0_d[1] = s0_dlon;
  assign s0_d[2] = s0_la;
  assign s0_d[3] = s0_lb;
  genvar gk, gi;
  generate
    for (gk = 0; gk < 4; gk++) begin : g_ph
      localparam int SH = (gk < 2) ? 12 : 13;
      logic [25:0] s1_mag, s2_mag;
      logic [19:0] s2_a, s3_a, s4_a;
      logic [18:0] s3_c;
      logic [12:0] s4_f;
      logic [3:0] neg;
      logic [31:0] pm;
      assign pm = ({12'd0, s4_a} << SH) | {19'd0, s4_f};
      always_ff @(posedge clk) begin
        if (adv) begin
          neg <= {neg[2:0], s0_d[gk][25]};
          s1_mag <= s0_d[gk][25] ? 26'(-s0_d[gk]) : 26'(s0_d[gk]);
          s2_mag <= s1_mag;
          s2_a <= 20'((53'(s1_mag) * 53'(RECIP_45)) >> 32);
          s3_a <= s2_a;
          s3_c <= (19'(6'(s2_mag - 26'(s2_a) * 26'd45)) << SH) + 19'd22;
          s4_a <= s3_a;
          s4_f <= 13'((39'(s3_c) * 39'(RECIP_45_FRAC)) >> 25);
          s5_p[gk] <= neg[3] ? 32'd0 - pm : pm;
        end
      end
    end
  endgenerate

  // Stage 6: quadrant and residual.
  rot_t rot [4][NSTEPS+1];
  logic [1:0] quad [4][NSTEPS+1];
  generate
    for (gk = 0; gk < 4; gk++) begin : g_rot
      logic [1:0] q0;
      logic [31:0] zr;
      assign q0 = 2'((s5_p[gk] + 32'h2000_0000) >> 30);
      assign zr = s5_p[gk] - {q0, 30'd0};
      always_ff @(posedge clk) begin
        if (adv) begin
          rot[gk][0].x <= GAIN_Q30;
          rot[gk][0].y <= '0;
          rot[gk][0].z <= 34'(signed'(zr));
          quad[gk][0] <= q0;
        end
      end
      for (gi = 0; gi < NSTEPS; gi++) begin : g_st
        always_ff @(posedge clk) begin
          if (adv) begin
            quad[gk][gi+1] <= quad[gk][gi];
            if (!rot[gk][gi].z[33]) begin
              rot[gk][gi+1].x <= rot[gk][gi].x - (rot[gk][gi].y >>> gi);
              rot[gk][gi+1].y <= rot[gk][gi].y + (rot[gk][gi].x >>> gi);
              rot[gk][gi+1].z <= rot[gk][gi].z - atan_phase(5'(gi));
            end else begin
              rot[gk][gi+1].x <= rot[gk][gi].x + (rot[gk][gi].y >>> gi);
              rot[gk][gi+1].y <= rot[gk][gi].y - (rot[gk][gi].x >>> gi);
              rot[gk][gi+1].z <= rot[gk][gi].z + atan_phase(5'(gi));
            end
          end
        end
      end
    end
  endgenerate

  // Stage 37: quadrant fold. Sines for 0,1; cosines for 2,3.
  logic signed [33:0] sc [4];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 2; k++) begin
        case (quad[k][NSTEPS])
          2'd0: sc[k] <= rot[k][NSTEPS].y;
          2'd1: sc[k] <= rot[k][NSTEPS].x;
          2'd2: sc[k] <= -rot[k][NSTEPS].y;
          default: sc[k] <= -rot[k][NSTEPS].x;
        endcase
      end
      for (int k = 2; k < 4; k++) begin
        case (quad[k][NSTEPS])
          2'd0: sc[k] <= rot[k][NSTEPS].x;
          2'd1: sc[k] <= -rot[k][NSTEPS].y;
          2'd2: sc[k] <= -rot[k][NSTEPS].x;
          default: sc[k] <= rot[k][NSTEPS].y;
        endcase
      end
    end
  end

  // Stages 38-40: products.
  logic signed [67:0] m_h, m_t;
  logic signed [33:0] p34_h, p34_t, p34_ca, p34_cb, p35_t, p35_cb, p35_h, p36_t, p36_h;
  assign m_h = sc[0] * sc[0] + 68'sd536870912;
  assign m_t = sc[1] * sc[1] + 68'sd536870912;
  always_ff @(posedge clk) begin
    if (adv) begin
      p34_h <= 34'(m_h >>> 30);
      p34_t <= 34'(m_t >>> 30);
      p34_ca <= sc[2];
      p34_cb <= sc[3];
      p35_t <= 34'((p34_t * p34_ca + 68'sd536870912) >>> 30);
      p35_cb <= p34_cb;
      p35_h <= p34_h;
      p36_t <= 34'((p35_t * p35_cb + 68'sd536870912) >>> 30);
      p36_h <= p35_h;
    end
  end

  // Stage 41: sum and clamp.
  logic signed [34:0] hs;
  logic [30:0] h37;
  assign hs = 35'(p36_h) + 35'(p36_t);
  always_ff @(posedge clk) begin
    if (adv) begin
      if (hs[34]) begin
        h37 <= '0;
      end else if (hs > 35'(Q30_ONE)) begin
        h37 <= 31'(Q30_ONE);
      end else begin
        h37 <= 31'(hs);
      end
    end
  end

  // Stages 42-73: two 31-step restoring square roots of 61-bit values.
  logic [61:0] rv [2][32];
  logic [31:0] rr [2][32];
  always_ff @(posedge clk) begin
    if (adv) begin
      rv[0][0] <= {1'b0, h37, 30'd0};
      rv[1][0] <= {1'b0, 31'(31'(Q30_ONE) - h37), 30'd0};
      rr[0][0] <= '0;
      rr[1][0] <= '0;
    end
  end
  generate
    for (gk = 0; gk < 2; gk++) begin : g_sq
      for (gi = 0; gi < 31; gi++) begin : g_b
        logic [63:0] trial;
        logic [63:0] rem;
        assign rem = {2'b00, rv[gk][gi]} >> (60 - 2 * gi);
        assign trial = {30'd0, rr[gk][gi], 2'b01};
        always_ff @(posedge clk) begin
          if (adv) begin
            if (rem >= trial) begin
              rv[gk][gi+1] <= rv[gk][gi] - 62'(trial << (60 - 2 * gi));
              rr[gk][gi+1] <= {rr[gk][gi][30:0], 1'b1};
            end else begin
              rv[gk][gi+1] <= rv[gk][gi];
              rr[gk][gi+1] <= {rr[gk][gi][30:0], 1'b0};
            end
          end
        end
      end
    end
  endgenerate

  // Stages 74-104: vectoring CORDIC.
  rot_t vec [NSTEPS+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      vec[0].x <= 34'(rr[1][31]);
      vec[0].y <= 34'(rr[0][31]);
      vec[0].z <= '0;
    end
  end
  generate
    for (gi = 0; gi < NSTEPS; gi++) begin : g_vec
      always_ff @(posedge clk) begin
        if (adv) begin
          if (!vec[gi].y[33]) begin
            vec[gi+1].x <= vec[gi].x + (vec[gi].y >>> gi);
            vec[gi+1].y <= vec[gi].y - (vec[gi].x >>> gi);
            vec[gi+1].z <= vec[gi].z + atan_phase(5'(gi));
          end else begin
            vec[gi+1].x <= vec[gi].x - (vec[gi].y >>> gi);
            vec[gi+1].y <= vec[gi].y + (vec[gi].x >>> gi);
            vec[gi+1].z <= vec[gi].z - atan_phase(5'(gi));
          end
        end
      end
    end
  endgenerate

  // Stages 105-109: scale to meters in 16/17-bit partial products, saturate.
  logic [32:0] za;
  logic [43:0] pl;
  logic [43:0] ph;
  logic [60:0] dsum;
  logic [28:0] dm;
  always_ff @(posedge clk) begin
    if (adv) begin
      za <= vec[NSTEPS].z[33] ? '0 : vec[NSTEPS].z[32:0];
      pl <= 44'(za[15:0]) * 44'(FOUR_PI_R_M);
      ph <= 44'(za[32:16]) * 44'(FOUR_PI_R_M);
      dsum <= ({17'd0, ph} << 16) + 61'(pl) + 61'h8000_0000;
      dm <= 29'(dsum >> 32);
      distance_m <= (dm > 29'(HALF_CIRC_M)) ? HALF_CIRC_M : dm[24:0];
    end
  end

endmodule
